// ===== rtl/assert_macros.svh =====
// assertion macros used by compacting_tracked_list_core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, checked out of reset
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/ctl_pkg.sv =====
// package for the compacting tracked list: constants and transaction types
`timescale 1ns / 1ps
`default_nettype none

package ctl_pkg;

  localparam int CAPACITY  = 24;
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int HANDLE_W  = 32;
  localparam int OUT_CNT_W = 5;

  localparam logic REQ_APPEND = 1'b0;
  localparam logic REQ_REMOVE = 1'b1;

  typedef struct packed {
    logic                req_type;
    logic [HANDLE_W-1:0] item_handle;
  } in_item_t;

  typedef struct packed {
    logic                 done_res;
    logic [OUT_CNT_W-1:0] entry_count;
  } out_item_t;

  typedef struct packed {
    logic valid;
    logic load;
    logic shift_en;
  } cell_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/ctl_cell.sv =====
// one list slot: holds an entry, matches the handle, shifts down on remove
`timescale 1ns / 1ps
`default_nettype none

module ctl_cell
  import ctl_pkg::*;
(
  input  wire logic                clk,
  input  wire cell_ctl_t           ctl_i,
  input  wire logic [HANDLE_W-1:0] handle_i,
  input  wire logic [HANDLE_W-1:0] upper_i,
  input  wire logic                above_i,
  output logic                     above_o,
  output logic      [HANDLE_W-1:0] entry_o
);

  logic [HANDLE_W-1:0] entry_r;
  logic [HANDLE_W-1:0] entry_nxt;
  logic                match;

  assign match   = ctl_i.valid & (entry_r == handle_i);
  assign above_o = above_i | match;
  assign entry_o = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    if (ctl_i.load) begin
      entry_nxt = handle_i;
    end else if (ctl_i.shift_en & ~above_i) begin
      entry_nxt = upper_i;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

`default_nettype wire

// ===== rtl/compacting_tracked_list_core.sv =====
// top level of the compacting tracked list: cell chain, count and result register
//
// channel  direction  payload     handshake
// in_      input      in_item_t   in_valid / in_stall
// out_     output     out_item_t  out_valid / out_stall
//
// one transaction per cycle while in_stall is low; the result shows in the cycle after acceptance
// the match search ripples through the row of 24 cells in the accepting cycle
// reset clears the count and the result valid; entries hold no reset value
// in_stall rises only when a result waits and out_stall is high
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module compacting_tracked_list_core
  import ctl_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data
);

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             out_valid_r;
  logic             out_valid_nxt;
  out_item_t        out_data_r;
  out_item_t        out_data_nxt;

  logic             in_acc;
  logic             app_ok;
  logic             found;
  logic             is_remove;

  logic      [CAPACITY:0]  above;
  logic      [HANDLE_W-1:0] entry [CAPACITY];
  cell_ctl_t [CAPACITY-1:0] cell_ctl;

  assign in_stall  = out_valid_r & out_stall;
  assign in_acc    = in_valid & ~in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign is_remove = (in_data.req_type == REQ_REMOVE);
  assign app_ok    = in_acc & ~is_remove & (count_r < CNT_W'(CAPACITY));
  assign above[CAPACITY] = 1'b0;
  assign found     = above[0];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [HANDLE_W-1:0] upper;

    if (i == CAPACITY - 1) begin : g_top
      assign upper = entry[i];
    end else begin : g_mid
      assign upper = entry[i+1];
    end

    assign cell_ctl[i].valid    = (CNT_W'(i) < count_r);
    assign cell_ctl[i].load     = app_ok & (count_r == CNT_W'(i));
    assign cell_ctl[i].shift_en = in_acc & is_remove & found;

    ctl_cell u_cell (
      .clk      (clk),
      .ctl_i    (cell_ctl[i]),
      .handle_i (in_data.item_handle),
      .upper_i  (upper),
      .above_i  (above[i+1]),
      .above_o  (above[i]),
      .entry_o  (entry[i])
    );
  end

  always_comb begin
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r & out_stall;
    out_data_nxt  = out_data_r;
    if (in_acc) begin
      if (app_ok) begin
        count_nxt = count_r + CNT_W'(1);
      end else if (is_remove & found) begin
        count_nxt = count_r - CNT_W'(1);
      end
      out_valid_nxt            = 1'b1;
      out_data_nxt.done_res    = app_ok | (is_remove & found);
      out_data_nxt.entry_count = OUT_CNT_W'(count_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  `ASSERT_SAME(a_count_bound, 1'b1, count_r <= CNT_W'(CAPACITY))
  `ASSERT_NEXT(a_remove_dec, in_acc && is_remove && found, count_r == $past(count_r) - CNT_W'(1))
  `ASSERT_NEXT(a_append_inc, app_ok, count_r == $past(count_r) + CNT_W'(1) && out_data_r.done_res)
  `ASSERT_NEXT(a_acc_result, in_acc, out_valid_r)

endmodule

`default_nettype wire
